>>> rtl/atl_pkg.sv
// Package for the arithmetic token lexer: character classes, state codes,
// the state transition table and the result type. No dependencies.
package atl_pkg;

  localparam int MAX_TOKEN_LEN = 255;
  localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [3:0] CLS_PLUS   = 4'd0;
  localparam logic [3:0] CLS_MINUS  = 4'd1;
  localparam logic [3:0] CLS_MUL    = 4'd2;
  localparam logic [3:0] CLS_DIV    = 4'd3;
  localparam logic [3:0] CLS_POW    = 4'd4;
  localparam logic [3:0] CLS_ASSIGN = 4'd5;
  localparam logic [3:0] CLS_LPAREN = 4'd6;
  localparam logic [3:0] CLS_RPAREN = 4'd7;
  localparam logic [3:0] CLS_LETTER = 4'd8;
  localparam logic [3:0] CLS_DIGIT  = 4'd9;
  localparam logic [3:0] CLS_POINT  = 4'd10;
  localparam logic [3:0] CLS_SPACE  = 4'd11;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;

  localparam logic [3:0] ST_START  = 4'd0;
  localparam logic [3:0] ST_ERROR  = 4'd13;
  localparam logic [3:0] KIND_ERROR = 4'd12;

  localparam logic [3:0] NEXT_STATE [15][12] = '{
    '{4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd5, 4'd6, 4'd1, 4'd2, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd1, 4'd1, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd2, 4'd14, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd3, 4'd13, 4'd0},
    '{4'd4, 4'd4, 4'd4, 4'd4,  4'd4,  4'd4,  4'd4, 4'd4, 4'd4, 4'd4, 4'd4,  4'd4},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd4,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd3, 4'd13, 4'd13}
  };

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] token_length;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [3:0] char_class(input logic [7:0] c);
    logic [3:0] cls;
    cls = CLS_PLUS;
    priority if (c == CH_MINUS) cls = CLS_MINUS;
    else if (c == CH_MUL) cls = CLS_MUL;
    else if (c == CH_DIV) cls = CLS_DIV;
    else if (c == CH_POW) cls = CLS_POW;
    else if (c == CH_ASSIGN) cls = CLS_ASSIGN;
    else if (c == CH_LPAREN) cls = CLS_LPAREN;
    else if (c == CH_RPAREN) cls = CLS_RPAREN;
    else if (c == CH_POINT) cls = CLS_POINT;
    else if (c == CH_SPACE) cls = CLS_SPACE;
    else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z))
      cls = CLS_LETTER;
    else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) cls = CLS_DIGIT;
    else cls = CLS_PLUS;
    return cls;
  endfunction

  function automatic logic [3:0] kind_of(input logic [3:0] s);
    return (s != ST_START && s <= ST_ERROR) ? s - 4'd1 : KIND_ERROR;
  endfunction

endpackage

>>> rtl/atl_if.sv
// Request channel interfaces for the arithmetic token lexer.
// Depends on nothing; one interface for characters, one for tokens.
interface atl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source(output valid, char_code, end_of_line, input ready);
  modport sink(input valid, char_code, end_of_line, output ready);
endinterface

interface atl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_length;
  logic       last;

  modport source(output valid, token_kind, token_length, last, input ready);
  modport sink(input valid, token_kind, token_length, last, output ready);
endinterface

>>> rtl/atl_result_queue.sv
// Three-entry result queue that drives the token channel.
// Depends on atl_pkg and atl_out_if.
module atl_result_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  atl_pkg::push_t  push,
  output logic            room,
  atl_out_if.source       out_chan
);

  logic [1:0]       count_r, count_nxt, base;
  atl_pkg::result_t q_r [3];
  atl_pkg::result_t q_nxt [3];
  logic             pop;

  assign pop  = (count_r != 2'd0) && out_chan.ready;
  assign room = (count_r <= 2'd1);

  assign out_chan.valid        = (count_r != 2'd0);
  assign out_chan.token_kind   = q_r[0].token_kind;
  assign out_chan.token_length = q_r[0].token_length;
  assign out_chan.last         = q_r[0].last;

  always_comb begin
    base     = count_r - {1'b0, pop};
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push.n != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = push.first;
      end
      if (push.n == 2'd2 && base + 2'd1 == 2'(i)) begin
        q_nxt[i] = push.second;
      end
    end
    count_nxt = base + push.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

>>> rtl/arithmetic_token_lexer.sv
// Arithmetic token lexer: takes one character per request and returns token
// kind and length requests. It steps a 15-state table once per character, so
// a character is taken every cycle while the queue has room; its tokens are queued.
// A character that ends one token, opens another and ends its line yields two
// tokens; the three-entry result queue then holds off input while it drains.
// Depends on atl_pkg, atl_if and atl_result_queue.
module arithmetic_token_lexer (
  input  logic       clk,
  input  logic       rst_n,
  atl_in_if.sink     in_chan,
  atl_out_if.source  out_chan
);

  logic [3:0]               state_r, state_nxt;
  logic [atl_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [atl_pkg::CNT_W-1:0] cnt_step;
  logic [3:0]               cls, nx;
  logic                     fall, flush, accept, room;
  atl_pkg::result_t         res_fall, res_flush;
  atl_pkg::push_t           push;

  assign accept = in_chan.valid && room;
  assign in_chan.ready = room;

  always_comb begin
    cls      = atl_pkg::char_class(in_chan.char_code);
    nx       = atl_pkg::NEXT_STATE[state_r][cls];
    fall     = (nx == atl_pkg::ST_START) && (state_r != atl_pkg::ST_START);
    cnt_step = cnt_r;
    if (fall) begin
      cnt_step = '0;
      if (cls != atl_pkg::CLS_SPACE) begin
        nx       = atl_pkg::NEXT_STATE[atl_pkg::ST_START][cls];
        cnt_step = atl_pkg::CNT_W'(1);
      end
    end else if (nx != atl_pkg::ST_START) begin
      if (cnt_r < atl_pkg::CNT_W'(atl_pkg::MAX_TOKEN_LEN)) begin
        cnt_step = cnt_r + atl_pkg::CNT_W'(1);
      end
    end
    flush = in_chan.end_of_line && (nx != atl_pkg::ST_START);

    res_fall.token_kind    = atl_pkg::kind_of(state_r);
    res_fall.token_length  = 8'(cnt_r);
    res_fall.last          = !flush;
    res_flush.token_kind   = atl_pkg::kind_of(nx);
    res_flush.token_length = 8'(cnt_step);
    res_flush.last         = 1'b1;

    push.n      = 2'd0;
    push.first  = res_fall;
    push.second = res_flush;
    if (accept) begin
      unique case ({fall, flush})
        2'b11: push.n = 2'd2;
        2'b10: push.n = 2'd1;
        2'b01: begin
          push.n     = 2'd1;
          push.first = res_flush;
        end
        default: push.n = 2'd0;
      endcase
    end

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      state_nxt = in_chan.end_of_line ? atl_pkg::ST_START : nx;
      cnt_nxt   = in_chan.end_of_line ? '0 : cnt_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atl_pkg::ST_START;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  atl_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/atl_checker.sv
// Port-level checks for the arithmetic token lexer, bound to the top level.
// Depends on the ports of arithmetic_token_lexer only.
module atl_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_token_kind,
  input logic [7:0] out_token_length,
  input logic       out_last
);

  localparam logic [3:0] KindMax = 4'd12;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Token output valid right after reset.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KindMax)
    else $error("Token kind out of range.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind)
      && $stable(out_token_length) && $stable(out_last))
    else $error("Stalled token request changed.");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("Token without last flag not followed by its partner.");

endmodule

bind arithmetic_token_lexer atl_port_checker u_atl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_token_kind   (out_chan.token_kind),
  .out_token_length (out_chan.token_length),
  .out_last         (out_chan.last)
);

>>> sim/atl_checker.sv
`timescale 1ns / 100ps
// Checker for the arithmetic token lexer: watches the character and token
// channels, predicts each token and compares it. Depends on atl_pkg and atl_if.
module atl_checker (
  input  logic clk,
  input  logic rst_n,
  atl_in_if    in_chan,
  atl_out_if   out_chan,
  output int   fail_count,
  output int   tokens_pending
);
  import atl_pkg::*;

  localparam logic [3:0] LEX_TABLE [15][12] = '{
    '{4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd5, 4'd6, 4'd1, 4'd2, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd14, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd13, 4'd0},
    '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd13, 4'd0},
    '{4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd3, 4'd13, 4'd13}
  };

  logic [3:0] lex_state;
  logic [7:0] token_len;
  result_t    expected_tokens[$];
  int         mismatches = 0;
  int         pending = 0;

  assign fail_count     = mismatches;
  assign tokens_pending = pending;

  function automatic logic [3:0] classify(input logic [7:0] c);
    case (c)
      CH_MINUS:  return CLS_MINUS;
      CH_MUL:    return CLS_MUL;
      CH_DIV:    return CLS_DIV;
      CH_POW:    return CLS_POW;
      CH_ASSIGN: return CLS_ASSIGN;
      CH_LPAREN: return CLS_LPAREN;
      CH_RPAREN: return CLS_RPAREN;
      CH_POINT:  return CLS_POINT;
      CH_SPACE:  return CLS_SPACE;
      default: begin
        if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z))
          return CLS_LETTER;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
          return CLS_DIGIT;
        return CLS_PLUS;
      end
    endcase
  endfunction

  function automatic logic [3:0] kind_for(input logic [3:0] s);
    if (s != ST_START && s <= ST_ERROR)
      return s - 4'd1;
    return KIND_ERROR;
  endfunction

  task automatic lex_char(input logic [7:0] c, input logic eol);
    logic [3:0] cls;
    logic [3:0] nxt;
    result_t    toks[2];
    int         n;
    n = 0;
    cls = classify(c);
    nxt = LEX_TABLE[lex_state][cls];
    if (nxt == ST_START && lex_state != ST_START) begin
      toks[n] = '{token_kind: kind_for(lex_state), token_length: token_len, last: 1'b0};
      n++;
      token_len = '0;
      // A character other than a space opens the next token.
      if (cls != CLS_SPACE) begin
        nxt = LEX_TABLE[ST_START][cls];
        token_len = 8'd1;
      end
    end else if (nxt != ST_START) begin
      if (token_len < MAX_TOKEN_LEN)
        token_len++;
    end
    lex_state = nxt;
    if (eol) begin
      if (lex_state != ST_START) begin
        toks[n] = '{token_kind: kind_for(lex_state), token_length: token_len, last: 1'b0};
        n++;
      end
      lex_state = ST_START;
      token_len = '0;
    end
    if (n > 0)
      toks[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++)
      expected_tokens.push_back(toks[i]);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      lex_state = ST_START;
      token_len = '0;
      expected_tokens.delete();
    end else begin
      if (in_chan.valid && in_chan.ready)
        lex_char(in_chan.char_code, in_chan.end_of_line);
      if (out_chan.valid && out_chan.ready) begin
        got = '{token_kind: out_chan.token_kind, token_length: out_chan.token_length,
                last: out_chan.last};
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected token: expected none, got kind %0d length %0d last %0b",
                   $time, got.token_kind, got.token_length, got.last);
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_kind !== want.token_kind || got.token_length !== want.token_length ||
              got.last !== want.last) begin
            mismatches++;
            $display("%0t: token mismatch: expected kind %0d length %0d last %0b, got kind %0d length %0d last %0b",
                     $time, want.token_kind, want.token_length, want.last,
                     got.token_kind, got.token_length, got.last);
          end
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the arithmetic token lexer testbench: clock, reset, character lines
// and receiver stalls. Depends on atl_pkg, atl_if, the lexer and atl_checker.
module tb_top;
  import atl_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_CHARS  = 530;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   tokens_pending;
  int   sender_idle_pct = 38;
  int   receiver_idle_pct = 86;
  int   chars_sent = 0;
  int   cycle_count = 0;
  logic [7:0] line_buf[$];

  atl_in_if  in_chan();
  atl_out_if out_chan();

  always #(CLK_HALF) clk = ~clk;

  arithmetic_token_lexer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  atl_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .fail_count     (fail_count),
    .tokens_pending (tokens_pending)
  );

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0)
      return CH_UPPER_A + 8'($urandom_range(25));
    return CH_LOWER_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_DIGIT_0 + 8'($urandom_range(9));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eol);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.char_code   <= c;
    in_chan.end_of_line <= eol;
    @(posedge clk);
    while (!in_chan.ready)
      @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic eol);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eol && (i == s.len() - 1));
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic add_digits(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) line_buf.push_back(rand_digit());
  endtask

  task automatic add_token(input int sel);
    int n;
    case (sel)
      0: begin
        line_buf.push_back(rand_letter());
        n = $urandom_range(6);
        repeat (n) line_buf.push_back($urandom_range(1) ? rand_letter() : rand_digit());
      end
      1: add_digits(1, 5);
      2: begin
        add_digits(1, 4);
        line_buf.push_back(CH_POINT);
        add_digits(1, 3);
      end
      3: begin
        line_buf.push_back(CH_DIV);
        line_buf.push_back(CH_DIV);
        n = $urandom_range(8);
        repeat (n) line_buf.push_back(8'($urandom_range(255)));
      end
      4: line_buf.push_back(CH_LPAREN);
      5: line_buf.push_back(CH_RPAREN);
      6: line_buf.push_back(8'h2B);
      7: line_buf.push_back(CH_MINUS);
      8: line_buf.push_back(CH_MUL);
      9: line_buf.push_back(CH_DIV);
      10: line_buf.push_back(CH_POW);
      default: line_buf.push_back(CH_ASSIGN);
    endcase
  endtask

  // Mostly well-formed expressions, with stray bytes, dangling points and
  // whole lines of noise mixed in.
  task automatic build_line();
    int n_tok;
    int r;
    int n;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(10, 1);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
      return;
    end
    n_tok = $urandom_range(8, 1);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(2, 1)) line_buf.push_back(CH_SPACE);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        line_buf.push_back(8'($urandom_range(255)));
      end else if (r < 14) begin
        add_digits(0, 3);
        line_buf.push_back(CH_POINT);
        if ($urandom_range(1) == 0)
          line_buf.push_back(CH_SPACE);
        line_buf.push_back($urandom_range(1) ? rand_letter() : 8'($urandom_range(255)));
      end else begin
        add_token($urandom_range(11));
      end
      n = $urandom_range(2);
      repeat (n) line_buf.push_back(CH_SPACE);
    end
  endtask

  task automatic build_long_line();
    int n;
    n = $urandom_range(280, 256);
    if ($urandom_range(1) == 0) begin
      line_buf.push_back(CH_DIV);
      line_buf.push_back(CH_DIV);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      line_buf.push_back(rand_letter());
      repeat (n) line_buf.push_back($urandom_range(1) ? rand_letter() : rand_digit());
      line_buf.push_back(CH_SPACE);
      add_token($urandom_range(11));
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    int budget;
    sender_idle_pct   = s_idle;
    receiver_idle_pct = r_idle;
    budget = chars_sent + PHASE_CHARS;
    build_long_line();
    send_line();
    while (chars_sent < budget) begin
      build_line();
      send_line();
    end
  endtask

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[arithmetic_token_lexer] ERROR");
    $finish;
  end

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.char_code   = 8'h00;
    in_chan.end_of_line = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Leading space, letter and digit extremes, real, comment with spaces.
    send_text(" Az9", 1'b1);
    send_text("0.9", 1'b1);
    send_text("// .", 1'b1);
    // Every operator but division; the last one both falls back and flushes.
    send_text("()+-*^=", 1'b1);
    // Dangling point absorbing a space, then an error token.
    send_text("3. +", 1'b1);
    send_text("..", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);

    run_phase(38, 86);
    run_phase(86, 38);
    run_phase(0, 0);
    in_chan.valid <= 1'b0;

    wait (tokens_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && tokens_pending == 0)
      $display("[arithmetic_token_lexer] OK");
    else
      $display("[arithmetic_token_lexer] ERROR");
    $finish;
  end

endmodule
